[rtl/hrmse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hrmse_pkg;

	// Number of valid readings collected before the estimate is seeded (1..8)
	localparam int SEED_SAMPLES = 3;
	localparam int SEED_CNT_W   = $clog2(SEED_SAMPLES + 1);
	localparam int SEED_IDX_W   = (SEED_SAMPLES > 1) ? $clog2(SEED_SAMPLES) : 1;

	localparam int BPM_W   = 8;
	localparam int ALPHA_W = 9;
	localparam int EST_W   = 16;   // unsigned Q8.8

	// Full gain: 1.0 in Q1.8
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

	// Register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST   = ALPHA_W'(64);
	localparam logic [BPM_W-1:0]   BPM_MIN_RST = BPM_W'(10);
	localparam logic [BPM_W-1:0]   BPM_MAX_RST = BPM_W'(255);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_ALPHA = 2'd0,
		REG_BPM_MIN    = 2'd1,
		REG_BPM_MAX    = 2'd2
	} reg_idx_t;

	// Request kinds
	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic [ALPHA_W-1:0] gain_alpha;
		logic [BPM_W-1:0]   bpm_min;
		logic [BPM_W-1:0]   bpm_max;
	} cfg_t;

	typedef struct packed {
		logic [BPM_W-1:0] rate_out;
		logic             seeded;
	} res_t;

endpackage

`default_nettype wire

[rtl/heart_rate_median_seed_ema.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    kind, bpm
// out      out_valid / out_ready  rate_out, seeded
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle unless a reading waits on a stalled output. A request is
// registered at the input, processed from there by the combinational update (EMA
// multiply-add or median select), and its result lands in the output register.
// A restart request gives no result. The output register frees its slot in the
// cycle it is taken, so a stalled output holds only the one request behind it.
// Reset clears the estimate, seeding and registers to their defaults; cfg_ready
// is always high.

module heart_rate_median_seed_ema import hrmse_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [BPM_W-1:0]     bpm,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [BPM_W-1:0]          rate_out,
	output logic                      seeded,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ALPHA_W-1:0]   cfg_data
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic             kind_s1;
	logic [BPM_W-1:0] bpm_s1;
	logic             out_valid_q;
	res_t             out_q;
	res_t             core_res;
	logic             out_free;
	logic             go_s1;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_alpha <= ALPHA_RST;
			cfg_q.bpm_min    <= BPM_MIN_RST;
			cfg_q.bpm_max    <= BPM_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_ALPHA: cfg_q.gain_alpha <= cfg_data;
				REG_BPM_MIN:    cfg_q.bpm_min    <= cfg_data[BPM_W-1:0];
				REG_BPM_MAX:    cfg_q.bpm_max    <= cfg_data[BPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when it is a restart or the output slot is free
	assign out_free = !out_valid_q || out_ready;
	assign go_s1    = valid_s1 && ((kind_s1 == KIND_RESTART) || out_free);
	assign in_ready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			bpm_s1  <= bpm;
		end
	end

	hrmse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (go_s1),
		.kind   (kind_s1),
		.bpm    (bpm_s1),
		.res    (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && (kind_s1 == KIND_READING)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && (kind_s1 == KIND_READING)) begin
			out_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign rate_out  = out_q.rate_out;
	assign seeded    = out_q.seeded;

endmodule

`default_nettype wire

[rtl/hrmse_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module hrmse_core import hrmse_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             step,
	input  wire logic             kind,
	input  wire logic [BPM_W-1:0] bpm,
	output res_t                  res
);

	localparam int  MED_HI    = SEED_SAMPLES / 2;
	localparam int  MED_LO    = (SEED_SAMPLES / 2 > 0) ? SEED_SAMPLES / 2 - 1 : 0;
	localparam bit  SEED_EVEN = (SEED_SAMPLES % 2) == 0;

	logic [EST_W-1:0]      est_q;
	logic                  seeded_q;
	logic [SEED_CNT_W-1:0] cnt_q;
	logic [BPM_W-1:0]      seed_q [SEED_SAMPLES];

	logic                  in_range;
	logic [SEED_CNT_W-1:0] cnt_inc;
	logic                  seed_now;
	logic [ALPHA_W-1:0]    a_sat;
	logic [ALPHA_W-1:0]    a_inv;
	logic [EST_W+ALPHA_W-1:0] new_term;
	logic [EST_W+ALPHA_W-1:0] old_term;
	logic [EST_W+ALPHA_W:0] ema_sum;
	logic [EST_W-1:0]      ema_est;
	logic [EST_W-1:0]      med_est;
	logic [EST_W-1:0]      res_est;
	logic                  seeded_next;

	// Clamp the Q8.8 estimate to [lo, hi] (lower bound first), round to nearest
	function automatic logic [BPM_W-1:0] clamp_round(
		input logic [EST_W-1:0] est,
		input logic [BPM_W-1:0] lo,
		input logic [BPM_W-1:0] hi
	);
		logic [EST_W-1:0] y;
		logic [EST_W:0]   r;
		begin
			y = est;
			if (est < {lo, 8'h00}) begin
				y = {lo, 8'h00};
			end else if (est > {hi, 8'h00}) begin
				y = {hi, 8'h00};
			end
			r = {1'b0, y} + (EST_W + 1)'(128);
			return r[EST_W-1:8];
		end
	endfunction

	assign in_range = (bpm >= cfg.bpm_min) && (bpm <= cfg.bpm_max);
	assign cnt_inc  = cnt_q + SEED_CNT_W'(1);
	assign seed_now = !seeded_q && (cnt_inc == SEED_CNT_W'(SEED_SAMPLES));

	// EMA update: (a*z*256 + (256-a)*est + 128) >> 8
	always_comb begin
		a_sat    = (cfg.gain_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.gain_alpha;
		a_inv    = ALPHA_ONE - a_sat;
		new_term = {{EST_W{1'b0}}, a_sat} * {{ALPHA_W{1'b0}}, bpm, 8'h00};
		old_term = {{EST_W{1'b0}}, a_inv} * {{ALPHA_W{1'b0}}, est_q};
		ema_sum  = {1'b0, new_term} + {1'b0, old_term} + (EST_W + ALPHA_W + 1)'(128);
		ema_est  = ema_sum[EST_W+7:8];
	end

	// Median by rank: the newest reading fills the last slot
	always_comb begin
		logic [BPM_W-1:0]      vals [SEED_SAMPLES];
		logic [SEED_CNT_W-1:0] rank [SEED_SAMPLES];
		logic [BPM_W-1:0]      lo_v;
		logic [BPM_W-1:0]      hi_v;
		logic [BPM_W:0]        pair;
		for (int i = 0; i < SEED_SAMPLES; i++) begin
			vals[i] = (i == SEED_SAMPLES - 1) ? bpm : seed_q[i];
		end
		for (int i = 0; i < SEED_SAMPLES; i++) begin
			rank[i] = '0;
			for (int j = 0; j < SEED_SAMPLES; j++) begin
				if ((vals[j] < vals[i]) || ((j < i) && (vals[j] == vals[i]))) begin
					rank[i] = rank[i] + SEED_CNT_W'(1);
				end
			end
		end
		lo_v = '0;
		hi_v = '0;
		for (int i = 0; i < SEED_SAMPLES; i++) begin
			if (rank[i] == SEED_CNT_W'(MED_LO)) begin
				lo_v = vals[i];
			end
			if (rank[i] == SEED_CNT_W'(MED_HI)) begin
				hi_v = vals[i];
			end
		end
		pair = {1'b0, lo_v} + {1'b0, hi_v};
		if (SEED_EVEN) begin
			med_est = {pair, 7'b0};
		end else begin
			med_est = {hi_v, 8'h00};
		end
	end

	// Result for a reading request
	always_comb begin
		res_est     = est_q;
		seeded_next = seeded_q;
		if (in_range) begin
			if (seeded_q) begin
				res_est = ema_est;
			end else if (seed_now) begin
				res_est     = med_est;
				seeded_next = 1'b1;
			end
		end
		res.seeded   = seeded_next;
		res.rate_out = seeded_next ? clamp_round(res_est, cfg.bpm_min, cfg.bpm_max) : '0;
	end

	// Estimate and seeding state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q    <= '0;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else if (step) begin
			if (kind == KIND_RESTART) begin
				est_q    <= '0;
				seeded_q <= 1'b0;
				cnt_q    <= '0;
			end else if (in_range) begin
				if (seeded_q) begin
					est_q <= ema_est;
				end else if (seed_now) begin
					est_q    <= med_est;
					seeded_q <= 1'b1;
					cnt_q    <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	// Seed store, written only while collecting
	always_ff @(posedge clk) begin
		if (step && (kind == KIND_READING) && in_range && !seeded_q) begin
			seed_q[cnt_q[SEED_IDX_W-1:0]] <= bpm;
		end
	end

endmodule

`default_nettype wire

[tb/tb_heart_rate_median_seed_ema.sv]
`timescale 1ns / 1ps

module tb_heart_rate_median_seed_ema;
	import hrmse_pkg::*;

	// Index past the last register, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// Cycles to let the pipeline settle before a register write and at the end
	localparam int DRAIN_CYCLES = 6;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 75;
	localparam int QUIET_PHASE  = 4;

	typedef enum logic {
		ROW_REQUEST,
		ROW_CFG
	} row_op_t;

	typedef struct {
		row_op_t              op;
		logic [CFG_IDX_W-1:0] idx;
		logic [ALPHA_W-1:0]   data;
		logic                 kind;
		logic [BPM_W-1:0]     bpm;
		bit                   typed;
		res_t                 exp;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 kind      = KIND_READING;
	logic [BPM_W-1:0]     bpm       = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GAIN_ALPHA;
	logic [ALPHA_W-1:0]   cfg_data  = '0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 cfg_ready;
	logic [BPM_W-1:0]     rate_out;
	logic                 seeded;

	// Predictor copy of registers and filter state
	logic [ALPHA_W-1:0] cfg_alpha;
	logic [BPM_W-1:0]   cfg_min;
	logic [BPM_W-1:0]   cfg_max;
	logic [EST_W-1:0]   est_q88;
	logic               est_seeded;
	logic [BPM_W-1:0]   seed_vals [SEED_SAMPLES];
	int unsigned        seed_cnt;

	res_t      rate_expected [$];
	stim_row_t directed_rows [$];
	int        mismatches = 0;
	bit        no_idle    = 1'b0;

	heart_rate_median_seed_ema i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.bpm       (bpm),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rate_out  (rate_out),
		.seeded    (seeded),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Global watchdog
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Estimate clamped to the accepted range, rounded half up
	function automatic logic [BPM_W-1:0] clamp_round(input logic [EST_W-1:0] e);
		logic [EST_W-1:0] lo;
		logic [EST_W-1:0] hi;
		logic [EST_W-1:0] y;
		logic [EST_W:0]   sum;
		lo = {cfg_min, 8'h00};
		hi = {cfg_max, 8'h00};
		y  = e;
		if (y < lo) begin
			y = lo;
		end else if (y > hi) begin
			y = hi;
		end
		sum = {1'b0, y} + 17'd128;
		return sum[15:8];
	endfunction

	// Median of the collected readings in Q8.8
	function automatic logic [EST_W-1:0] median_seed();
		logic [BPM_W-1:0] v [SEED_SAMPLES];
		logic [BPM_W-1:0] key;
		int               i;
		int               j;
		v = seed_vals;
		for (i = 1; i < SEED_SAMPLES; i++) begin
			key = v[i];
			j   = i;
			while (j > 0 && v[j-1] > key) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = key;
		end
		if (SEED_SAMPLES % 2) begin
			return {v[SEED_SAMPLES/2], 8'h00};
		end
		return EST_W'(({1'b0, v[SEED_SAMPLES/2-1]} + {1'b0, v[SEED_SAMPLES/2]}) << 7);
	endfunction

	// Advance the smoother by one request; returns 1 when a result is due
	function automatic bit step_smoother(input logic k, input logic [BPM_W-1:0] z,
			output res_t r);
		logic [31:0] a;
		logic [31:0] acc;
		r = '0;
		if (k == KIND_RESTART) begin
			est_q88    = '0;
			est_seeded = 1'b0;
			seed_cnt   = 0;
			return 1'b0;
		end
		// rejected reading leaves state alone
		if (z < cfg_min || z > cfg_max) begin
			r.rate_out = est_seeded ? clamp_round(est_q88) : '0;
			r.seeded   = est_seeded;
			return 1'b1;
		end
		// collecting seed readings
		if (!est_seeded) begin
			if (seed_cnt < SEED_SAMPLES) begin
				seed_vals[seed_cnt] = z;
				seed_cnt++;
			end
			if (seed_cnt < SEED_SAMPLES) begin
				return 1'b1;
			end
			est_q88    = median_seed();
			est_seeded = 1'b1;
			seed_cnt   = 0;
			r.rate_out = clamp_round(est_q88);
			r.seeded   = 1'b1;
			return 1'b1;
		end
		// EMA update, gain saturates at one
		a   = (cfg_alpha > ALPHA_ONE) ? 32'(ALPHA_ONE) : 32'(cfg_alpha);
		acc = a * {16'h0, z, 8'h00} + (32'd256 - a) * {16'h0, est_q88} + 32'd128;
		est_q88    = acc[23:8];
		r.rate_out = clamp_round(est_q88);
		r.seeded   = 1'b1;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Sink side: random back-pressure except in the quiet phase
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 10);
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rate_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result rate_out=%0d seeded=%0b",
					rate_out, seeded));
			end else begin
				want = rate_expected.pop_front();
				if (rate_out !== want.rate_out) begin
					report_mismatch($sformatf("rate_out %0d, expected %0d",
						rate_out, want.rate_out));
				end
				if (seeded !== want.seeded) begin
					report_mismatch($sformatf("seeded %0b, expected %0b",
						seeded, want.seeded));
				end
			end
		end
	end

	// Drive one request, predict it on acceptance
	task automatic send_req(input logic k, input logic [BPM_W-1:0] b, input bit typed,
			input res_t typed_res);
		res_t r;
		bit   has;
		if (!no_idle && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		bpm      <= b;
		do @(posedge clk); while (!(in_valid && in_ready));
		has = step_smoother(k, b, r);
		if (has) begin
			rate_expected.push_back(typed ? typed_res : r);
		end
	endtask

	// Stop sending and wait until every result is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (rate_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN_ALPHA: cfg_alpha = d;
			REG_BPM_MIN:    cfg_min   = d[BPM_W-1:0];
			REG_BPM_MAX:    cfg_max   = d[BPM_W-1:0];
			default: ;
		endcase
	endtask

	// Directed table builders
	function automatic void add_req(input logic k, input logic [BPM_W-1:0] b);
		stim_row_t row;
		row       = '{op: ROW_REQUEST, idx: REG_GAIN_ALPHA, data: '0, kind: k, bpm: b,
			typed: 1'b0, exp: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_exp(input logic [BPM_W-1:0] b, input logic [BPM_W-1:0] rate,
			input logic sd);
		stim_row_t row;
		row           = '{op: ROW_REQUEST, idx: REG_GAIN_ALPHA, data: '0, kind: KIND_READING,
			bpm: b, typed: 1'b1, exp: '0};
		row.exp.rate_out = rate;
		row.exp.seeded   = sd;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [ALPHA_W-1:0] d);
		stim_row_t row;
		row = '{op: ROW_CFG, idx: idx, data: d, kind: KIND_READING, bpm: '0,
			typed: 1'b0, exp: '0};
		directed_rows.push_back(row);
	endfunction

	initial begin : stimulus
		stim_row_t          row;
		res_t               none;
		logic [ALPHA_W-1:0] gain;
		logic [BPM_W-1:0]   lo_b;
		logic [BPM_W-1:0]   hi_b;
		int                 pick;
		int                 ph;
		int                 n;

		none       = '0;
		cfg_alpha  = ALPHA_RST;
		cfg_min    = BPM_MIN_RST;
		cfg_max    = BPM_MAX_RST;
		est_q88    = '0;
		est_seeded = 1'b0;
		seed_cnt   = 0;
		for (n = 0; n < SEED_SAMPLES; n++) begin
			seed_vals[n] = '0;
		end

		// Reset defaults: rejection below minimum, restart mid-seed, seed on median
		add_exp(8'd0, 8'd0, 1'b0);
		add_exp(8'd255, 8'd0, 1'b0);
		add_req(KIND_RESTART, 8'd255);
		add_exp(8'd10, 8'd0, 1'b0);
		add_exp(8'd200, 8'd0, 1'b0);
		add_exp(8'd9, 8'd0, 1'b0);
		add_exp(8'd255, 8'd200, 1'b1);
		add_req(KIND_READING, 8'd255);
		add_req(KIND_READING, 8'd0);
		// full gain tracks the reading exactly, both ends of the range
		add_cfg(REG_GAIN_ALPHA, ALPHA_ONE);
		add_cfg(REG_BPM_MIN, 9'd0);
		add_cfg(REG_BPM_MAX, 9'd255);
		add_exp(8'd0, 8'd0, 1'b1);
		add_exp(8'd255, 8'd255, 1'b1);
		// zero gain freezes the estimate; output clamped at the top
		add_cfg(REG_GAIN_ALPHA, 9'd0);
		add_cfg(REG_BPM_MIN, 9'd150);
		add_cfg(REG_BPM_MAX, 9'd200);
		add_exp(8'd100, 8'd200, 1'b1);
		add_exp(8'd150, 8'd200, 1'b1);
		// gain above one saturates; min above max rejects all, upper clamp wins
		add_cfg(REG_GAIN_ALPHA, 9'd511);
		add_cfg(REG_BPM_MIN, 9'd200);
		add_cfg(REG_BPM_MAX, 9'd100);
		add_exp(8'd150, 8'd100, 1'b1);
		add_req(KIND_RESTART, 8'h5A);
		add_exp(8'd150, 8'd0, 1'b0);
		// write past the last register; single-value window
		add_cfg(REG_UNUSED, 9'h1FF);
		add_cfg(REG_BPM_MIN, 9'd77);
		add_cfg(REG_BPM_MAX, 9'd77);
		add_exp(8'd77, 8'd0, 1'b0);
		add_exp(8'd76, 8'd0, 1'b0);
		add_exp(8'd78, 8'd0, 1'b0);
		add_exp(8'd77, 8'd0, 1'b0);
		add_exp(8'd77, 8'd77, 1'b1);
		add_req(KIND_READING, 8'd77);
		// smallest gain, seed at zero
		add_cfg(REG_GAIN_ALPHA, 9'd1);
		add_cfg(REG_BPM_MIN, 9'd0);
		add_cfg(REG_BPM_MAX, 9'd255);
		add_req(KIND_RESTART, 8'd0);
		add_exp(8'd0, 8'd0, 1'b0);
		add_exp(8'd0, 8'd0, 1'b0);
		add_exp(8'd1, 8'd0, 1'b1);
		add_req(KIND_READING, 8'd255);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.op == ROW_CFG) begin
				write_reg(row.idx, row.data);
			end else begin
				send_req(row.kind, row.bpm, row.typed, row.exp);
			end
		end

		// Random phases, each with its own register setting
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0:       gain = '0;
				1:       gain = 9'd1;
				2:       gain = ALPHA_ONE;
				3:       gain = ALPHA_W'($urandom_range(257, 511));
				4:       gain = 9'd255;
				default: gain = ALPHA_W'($urandom_range(0, 256));
			endcase
			case ($urandom_range(0, 7))
				0:       lo_b = 8'd0;
				1:       lo_b = 8'd255;
				default: lo_b = BPM_W'($urandom_range(0, 100));
			endcase
			case ($urandom_range(0, 7))
				0:       hi_b = 8'd255;
				1:       hi_b = 8'd0;
				2:       hi_b = BPM_W'($urandom_range(0, 255));
				default: hi_b = BPM_W'($urandom_range(lo_b, 255));
			endcase
			write_reg(REG_GAIN_ALPHA, gain);
			write_reg(REG_BPM_MIN, {1'b0, lo_b});
			write_reg(REG_BPM_MAX, {1'b0, hi_b});
			no_idle <= (ph == QUIET_PHASE);
			if ($urandom_range(0, 1)) begin
				send_req(KIND_RESTART, BPM_W'($urandom), 1'b0, none);
			end
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					send_req(KIND_RESTART, BPM_W'($urandom), 1'b0, none);
				end else if (pick < 15 || cfg_min > cfg_max) begin
					send_req(KIND_READING, BPM_W'($urandom), 1'b0, none);
				end else begin
					send_req(KIND_READING, BPM_W'($urandom_range(cfg_min, cfg_max)),
						1'b0, none);
				end
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[heart_rate_median_seed_ema.f]
rtl/hrmse_pkg.sv
rtl/hrmse_core.sv
rtl/heart_rate_median_seed_ema.sv
tb/tb_heart_rate_median_seed_ema.sv
